### src/cop_pkg.sv
// ----------------------------------------------------------------------------
// Connector over-temperature protector package
// Shared types and constants for the protector core and its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cop_pkg;

   // operation codes carried in req_tuser
   localparam logic OP_CHARGER = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // register indexes on the csr port
   localparam logic [1:0] REG_PROTECT_ON = 2'd0;
   localparam logic [1:0] REG_OPEN_THR   = 2'd1;
   localparam logic [1:0] REG_CLOSE_THR  = 2'd2;
   localparam logic [1:0] REG_FAST_THR   = 2'd3;

   // sequencer counts
   localparam logic signed [11:0] CNT_INSERT = 12'sd1100;
   localparam logic signed [11:0] CNT_END    = 12'sd1001;
   localparam logic signed [11:0] CNT_STABLE = -12'sd1;

   // tick intervals in ms
   localparam logic [9:0] DELAY_NONE   = 10'd0;
   localparam logic [9:0] DELAY_FAST   = 10'd300;
   localparam logic [9:0] DELAY_NORMAL = 10'd1000;

   // reciprocal of 10 in 0.16 fixed point, exact for magnitudes up to 4096
   localparam logic [12:0] RECIP_TEN = 13'd6554;

   // saturation bounds of the rise
   localparam logic signed [11:0] RISE_MAX = 12'sd511;
   localparam logic signed [11:0] RISE_MIN = -12'sd512;

   // register reset values
   localparam logic signed [9:0] OPEN_THR_RST  = 10'sd40;
   localparam logic signed [9:0] CLOSE_THR_RST = 10'sd30;
   localparam logic signed [9:0] FAST_THR_RST  = 10'sd15;

   typedef struct packed {
      logic signed [9:0] fast_threshold;
      logic signed [9:0] close_threshold;
      logic signed [9:0] open_threshold;
      logic              protect_on;
   } cfg_type;

   typedef struct packed {
      logic               fast_interval;
      logic               wake_flag;
      logic               protect_flag;
      logic               switch_state;
      logic               timer_running;
      logic signed [11:0] seq_count;
   } state_type;

   // input item, last field in the lowest bits
   typedef struct packed {
      logic               batt_valid;
      logic signed [12:0] batt_temp_tenths;
      logic signed [8:0]  conn_temp;
      logic               charger_absent;
      logic               usb_charger;
   } req_item_type;

   // result item, last field in the lowest bits
   typedef struct packed {
      logic signed [9:0]  temp_rise;
      logic signed [11:0] check_count;
      logic [9:0]         next_delay_ms;
      logic               monitoring;
      logic               wake_hold;
      logic               protect_mode;
      logic               switch_open;
   } rsp_item_type;

   localparam state_type STATE_RST = '{
      fast_interval: 1'b0,
      wake_flag:     1'b0,
      protect_flag:  1'b0,
      switch_state:  1'b0,
      timer_running: 1'b0,
      seq_count:     CNT_INSERT
   };

endpackage

`default_nettype wire

### src/cop_core.sv
// ----------------------------------------------------------------------------
// Connector over-temperature protector core
// Next-state and result logic for one item: rise, sequencer and switch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cop_core
   import cop_pkg::*;
(
   input  wire logic         op,
   input  wire req_item_type item,
   input  wire cfg_type      cfg,
   input  wire state_type    cur,
   output state_type         nxt,
   output rsp_item_type      rsp
);

   logic [12:0]        batt_mag;
   logic [25:0]        batt_prod;
   logic [9:0]         batt_quot;
   logic signed [11:0] batt_deg;
   logic signed [11:0] rise_wide;
   logic signed [9:0]  rise;
   logic [9:0]         delay;
   logic signed [9:0]  rise_out;

   // battery tenths to degrees, truncated toward zero
   assign batt_mag  = item.batt_temp_tenths[12] ? 13'(-item.batt_temp_tenths)
                                                : 13'(item.batt_temp_tenths);
   assign batt_prod = 26'(batt_mag) * 26'(RECIP_TEN);
   assign batt_quot = batt_prod[25:16];
   assign batt_deg  = item.batt_temp_tenths[12] ? -$signed({2'b00, batt_quot})
                                                : $signed({2'b00, batt_quot});

   // rise of connector over battery, saturated
   assign rise_wide = 12'(item.conn_temp) - batt_deg;

   always_comb begin
      if (!item.batt_valid) begin
         rise = '0;
      end else if (rise_wide > RISE_MAX) begin
         rise = RISE_MAX[9:0];
      end else if (rise_wide < RISE_MIN) begin
         rise = RISE_MIN[9:0];
      end else begin
         rise = rise_wide[9:0];
      end
   end

   // state update for one item
   always_comb begin
      nxt      = cur;
      delay    = DELAY_NONE;
      rise_out = '0;
      if (op == OP_CHARGER) begin
         if (cfg.protect_on && item.usb_charger && !cur.timer_running) begin
            nxt.seq_count     = CNT_INSERT;
            nxt.timer_running = 1'b1;
         end
      end else if (cur.timer_running) begin
         if (cur.seq_count == CNT_STABLE && item.charger_absent) begin
            // charger gone while stable: stop monitoring
            nxt.switch_state  = 1'b0;
            nxt.fast_interval = 1'b0;
            nxt.protect_flag  = 1'b0;
            nxt.seq_count     = CNT_INSERT;
            nxt.timer_running = 1'b0;
         end else begin
            // check-count sequencer
            priority if (rise > cfg.fast_threshold) begin
               nxt.fast_interval = 1'b1;
               nxt.seq_count     = '0;
               nxt.protect_flag  = 1'b1;
            end else if (cur.seq_count > CNT_END) begin
               nxt.seq_count     = cur.seq_count - 12'sd1;
               nxt.fast_interval = 1'b1;
               nxt.protect_flag  = 1'b0;
            end else if (cur.seq_count == CNT_END) begin
               nxt.seq_count     = CNT_STABLE;
               nxt.fast_interval = 1'b0;
               nxt.protect_flag  = 1'b0;
               nxt.wake_flag     = 1'b0;
            end else if (cur.seq_count >= 12'sd0) begin
               nxt.seq_count     = cur.seq_count + 12'sd1;
               nxt.fast_interval = 1'b1;
               nxt.protect_flag  = 1'b1;
            end else begin
               nxt.fast_interval = 1'b0;
               nxt.protect_flag  = 1'b0;
            end
            // cutoff switch with hysteresis, open wins
            if (rise >= cfg.open_threshold) begin
               nxt.wake_flag    = 1'b1;
               nxt.switch_state = 1'b1;
            end else if (rise <= cfg.close_threshold) begin
               nxt.switch_state = 1'b0;
            end
            rise_out = rise;
            delay    = nxt.fast_interval ? DELAY_FAST : DELAY_NORMAL;
         end
      end
   end

   // result fields
   assign rsp.switch_open   = nxt.switch_state;
   assign rsp.protect_mode  = nxt.protect_flag;
   assign rsp.wake_hold     = nxt.wake_flag;
   assign rsp.monitoring    = nxt.timer_running;
   assign rsp.next_delay_ms = delay;
   assign rsp.check_count   = nxt.seq_count;
   assign rsp.temp_rise     = rise_out;

endmodule

`default_nettype wire

### src/connector_overtemp_protector.sv
// ----------------------------------------------------------------------------
// Connector over-temperature protector
// Watches connector-over-battery temperature rise and drives a cutoff switch.
// ----------------------------------------------------------------------------
// Every request gives exactly one response. A request passes through an
// input register and then combinational compare-and-count logic into the
// response register, so the block takes one request per clock while the
// response side does not stall; response valid is driven from the response
// register. Back pressure on the response side stalls the input register;
// the only multiplier is a 13x13 constant multiply that turns battery
// tenths into whole degrees. Registers on the csr port must be written
// only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module connector_overtemp_protector
   import cop_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // usb_charger, charger_absent, conn_temp, batt_temp_tenths, batt_valid
   input  wire logic [31:0] req_tdata,
   // operation
   input  wire logic        req_tuser,
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // switch_open, protect_mode, wake_hold, monitoring, next_delay_ms,
   // check_count, temp_rise
   output logic [39:0]      rsp_tdata,
   // register write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [9:0]  csr_data
);

   logic         in_valid_ff, in_valid_in;
   logic         in_op_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   state_type    state_ff, state_in;
   cfg_type      cfg_ff, cfg_in;
   rsp_item_type rsp_item;
   logic         advance;
   logic         req_xfer;

   // handshake control
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_PROTECT_ON: cfg_in.protect_on      = csr_data[0];
            REG_OPEN_THR:   cfg_in.open_threshold  = csr_data;
            REG_CLOSE_THR:  cfg_in.close_threshold = csr_data;
            REG_FAST_THR:   cfg_in.fast_threshold  = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   cop_core u_core (
      .op   (in_op_ff),
      .item (in_item_ff),
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .rsp  (rsp_item)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RST;
         cfg_ff       <= '{fast_threshold:  FAST_THR_RST,
                           close_threshold: CLOSE_THR_RST,
                           open_threshold:  OPEN_THR_RST,
                           protect_on:      1'b0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         if (advance && in_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_op_ff   <= req_tuser;
         in_item_ff <= req_tdata[24:0];
      end
      if (advance && in_valid_ff) begin
         rsp_item_ff <= rsp_item;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_item_ff};

`ifndef SYNTHESIS
   // an idle sequencer always rests at the insert count
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[3]) |-> (rsp_tdata[25:14] == CNT_INSERT))
      else $error("check count not at insert value while not monitoring");

   // a scheduled tick only exists while monitoring
   a_delay_mon: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[13:4] != DELAY_NONE) |-> rsp_tdata[3])
      else $error("tick delay given while not monitoring");

   // protect mode always runs at the fast interval
   a_protect_fast: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1] && rsp_tdata[13:4] != DELAY_NONE)
         |-> (rsp_tdata[13:4] == DELAY_FAST))
      else $error("protect mode with normal interval");

   // sequencer count stays within its legal span
   a_count_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff.seq_count >= CNT_STABLE && state_ff.seq_count <= CNT_INSERT))
      else $error("sequencer count out of range");
`endif

endmodule

`default_nettype wire
